FILE: hw/rtl/bmc_pkg.sv
package bmc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CHAR_BITS   = 16;

    localparam int CODE_W  = 16;
    localparam int POS_W   = 24;
    localparam int LINE_W  = 20;
    localparam int KIND_W  = 2;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);
    localparam logic [POS_W-1:0]  POS_MAX      = '1;
    localparam logic [LINE_W-1:0] LINE_MAX     = '1;

    localparam logic [CODE_W-1:0] OPEN_RESET  = CODE_W'(40);
    localparam logic [CODE_W-1:0] CLOSE_RESET = CODE_W'(41);

    localparam logic [KIND_W-1:0] KIND_CLOSE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VERDICT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

    localparam logic CFG_OPEN  = 1'b0;
    localparam logic CFG_CLOSE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [LINE_W-1:0] line;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

FILE: hw/rtl/bmc_if.sv
interface bmc_char_if;
    logic                        valid;
    logic                        ready;
    logic [bmc_pkg::CODE_W-1:0]  char_code;
    logic                        end_of_text;

    modport source (output valid, char_code, end_of_text, input ready);
    modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface bmc_report_if;
    logic                        valid;
    logic                        ready;
    logic [bmc_pkg::KIND_W-1:0]  report_kind;
    logic [bmc_pkg::POS_W-1:0]   char_position;
    logic [bmc_pkg::LINE_W-1:0]  line_number;
    logic                        all_matched;
    logic                        last_report;

    modport source (output valid, report_kind, char_position, line_number, all_matched,
                    last_report, input ready);
    modport sink   (input valid, report_kind, char_position, line_number, all_matched,
                    last_report, output ready);
endinterface

FILE: hw/rtl/bracket_match_checker.sv
// Checks one configured open/close symbol pair over a character stream. Open
// symbols are kept in a row of cells that shifts down on an open and up on a
// close, so the innermost open symbol always sits in the first cell. A close
// with nothing open, or an open that finds every cell full, is reported at
// once. A character is taken only while the block is idle and the single-entry
// output register is free or being taken. After the character marked
// end_of_text, each symbol still open is reported (innermost first, one cell
// shift each) and then the verdict; no character is taken during that flush.
// Write the configuration registers only while the block is idle.
module bracket_match_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bmc_pkg::CODE_W-1:0]    i_cfg_data,
    bmc_char_if.sink                      i_char,
    bmc_report_if.source                  o_rep
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic                               r_state, n_state;
    logic [bmc_pkg::CODE_W-1:0]         r_open, r_close;
    logic [bmc_pkg::POS_W-1:0]          r_chars, n_chars;
    logic [bmc_pkg::LINE_W-1:0]         r_lines, n_lines;
    logic [bmc_pkg::DEPTH_W-1:0]        r_depth, n_depth;
    logic                               r_mis, n_mis;
    logic                               r_ok, n_ok;

    logic                               r_ov, n_ov;
    logic [bmc_pkg::KIND_W-1:0]         r_kind, n_kind;
    logic [bmc_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [bmc_pkg::LINE_W-1:0]         r_line, n_line;
    logic                               r_all, n_all;
    logic                               r_last, n_last;

    bmc_pkg::t_shift                    shift;
    bmc_pkg::t_entry                    new_entry;
    bmc_pkg::t_entry                    cell_q [bmc_pkg::STACK_DEPTH];

    logic                               slot_free;
    logic                               accept;
    logic [bmc_pkg::CHAR_BITS-1:0]      code, op_code, cl_code;
    logic                               is_open, is_close;

    assign slot_free = !r_ov || o_rep.ready;
    assign i_char.ready = (r_state == ST_IDLE) && slot_free;
    assign accept = i_char.valid && i_char.ready;

    assign code    = i_char.char_code[bmc_pkg::CHAR_BITS-1:0];
    assign op_code = r_open[bmc_pkg::CHAR_BITS-1:0];
    assign cl_code = r_close[bmc_pkg::CHAR_BITS-1:0];
    assign is_open  = (code == op_code) && ((op_code != cl_code) || (r_depth == '0));
    assign is_close = !is_open && (code == cl_code);

    assign new_entry = '{pos: r_chars, line: r_lines};

    genvar gi;
    generate
        for (gi = 0; gi < bmc_pkg::STACK_DEPTH; gi++) begin : g_cell
            bmc_pkg::t_entry up_d, down_d;
            if (gi == 0) begin : g_first
                assign up_d = new_entry;
            end else begin : g_mid
                assign up_d = cell_q[gi-1];
            end
            if (gi == bmc_pkg::STACK_DEPTH - 1) begin : g_last
                assign down_d = '0;
            end else begin : g_inner
                assign down_d = cell_q[gi+1];
            end
            bmc_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_up    (up_d),
                .i_down  (down_d),
                .o_entry (cell_q[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_chars = r_chars;
        n_lines = r_lines;
        n_depth = r_depth;
        n_mis   = r_mis;
        n_ok    = r_ok;
        n_ov    = r_ov && !o_rep.ready;
        n_kind  = r_kind;
        n_pos   = r_pos;
        n_line  = r_line;
        n_all   = r_all;
        n_last  = r_last;
        shift   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (is_open) begin
                        if (r_depth < bmc_pkg::DEPTH_W'(bmc_pkg::STACK_DEPTH)) begin
                            shift.push = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end else begin
                            n_ov   = 1'b1;
                            n_kind = bmc_pkg::KIND_OVERFLOW;
                            n_pos  = r_chars;
                            n_line = r_lines;
                            n_all  = 1'b0;
                            n_last = 1'b0;
                            n_mis  = 1'b1;
                        end
                    end else if (is_close) begin
                        if (r_depth != '0) begin
                            shift.pop = 1'b1;
                            n_depth = r_depth - 1'b1;
                        end else begin
                            n_ov   = 1'b1;
                            n_kind = bmc_pkg::KIND_CLOSE;
                            n_pos  = r_chars;
                            n_line = r_lines;
                            n_all  = 1'b0;
                            n_last = 1'b0;
                            n_mis  = 1'b1;
                        end
                    end
                    if (r_chars != bmc_pkg::POS_MAX) begin
                        n_chars = r_chars + 1'b1;
                    end
                    if ((code == bmc_pkg::NEWLINE_CODE[bmc_pkg::CHAR_BITS-1:0])
                            && (r_lines != bmc_pkg::LINE_MAX)) begin
                        n_lines = r_lines + 1'b1;
                    end
                    if (i_char.end_of_text) begin
                        n_ok    = !n_mis && (n_depth == '0);
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    if (r_depth != '0) begin
                        n_kind    = bmc_pkg::KIND_OPEN;
                        n_pos     = cell_q[0].pos;
                        n_line    = cell_q[0].line;
                        n_all     = 1'b0;
                        n_last    = 1'b0;
                        shift.pop = 1'b1;
                        n_depth   = r_depth - 1'b1;
                    end else begin
                        n_kind  = bmc_pkg::KIND_VERDICT;
                        n_pos   = r_chars;
                        n_line  = r_lines;
                        n_all   = r_ok;
                        n_last  = 1'b1;
                        n_chars = '0;
                        n_lines = '0;
                        n_mis   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chars <= '0;
            r_lines <= '0;
            r_depth <= '0;
            r_mis   <= 1'b0;
            r_ok    <= 1'b0;
            r_ov    <= 1'b0;
            r_open  <= bmc_pkg::OPEN_RESET;
            r_close <= bmc_pkg::CLOSE_RESET;
        end else begin
            r_state <= n_state;
            r_chars <= n_chars;
            r_lines <= n_lines;
            r_depth <= n_depth;
            r_mis   <= n_mis;
            r_ok    <= n_ok;
            r_ov    <= n_ov;
            if (i_cfg_we && (i_cfg_idx == bmc_pkg::CFG_OPEN)) begin
                r_open <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == bmc_pkg::CFG_CLOSE)) begin
                r_close <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_pos  <= n_pos;
        r_line <= n_line;
        r_all  <= n_all;
        r_last <= n_last;
    end

    assign o_rep.valid         = r_ov;
    assign o_rep.report_kind   = r_kind;
    assign o_rep.char_position = r_pos;
    assign o_rep.line_number   = r_line;
    assign o_rep.all_matched   = r_all;
    assign o_rep.last_report   = r_last;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= bmc_pkg::DEPTH_W'(bmc_pkg::STACK_DEPTH))
        else $error("stack depth beyond cell count");

    a_no_take_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> !i_char.ready)
        else $error("character taken during flush");

    a_verdict_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_depth == '0 && slot_free)
            |=> (r_state == ST_IDLE && r_chars == '0 && r_lines == '0 && !r_mis
                 && r_ov && r_last))
        else $error("verdict did not close the run");

    a_match_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_all) |-> (r_last && r_kind == bmc_pkg::KIND_VERDICT))
        else $error("all_matched outside verdict");

endmodule

FILE: hw/rtl/bmc_cell.sv
module bmc_cell (
    input  logic            i_clk,
    input  bmc_pkg::t_shift i_shift,
    input  bmc_pkg::t_entry i_up,
    input  bmc_pkg::t_entry i_down,
    output bmc_pkg::t_entry o_entry
);

    bmc_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift.push) begin
            r_entry <= i_up;
        end else if (i_shift.pop) begin
            r_entry <= i_down;
        end
    end

    assign o_entry = r_entry;

endmodule
